// ===== rtl/pats_pkg.sv =====
// ----------------------------------------------------------------------------
// pats_pkg: shared types and constants of the pedal ADC to torque scaler
// Widths, register codes, the front-to-back queue entry and the divider
// stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package pats_pkg;

  // ADC sample width; the configuration registers share it
  localparam int ADC_BITS   = 12;
  localparam int SPAN_W     = ADC_BITS + 1;   // signed difference of two samples
  localparam int NUM_W      = ADC_BITS + 9;   // signed rounding numerator
  localparam int MAG_W      = ADC_BITS + 8;   // numerator magnitude / quotient
  localparam int Q_W        = MAG_W + 2;      // signed quotient after correction

  // Output fields
  localparam int PCT_W      = 16;
  localparam int TRQ_W      = 15;
  localparam int CLAMP_W    = 7;              // holds 0..100

  localparam int PCT_FULL   = 100;
  localparam int PCT_HALF   = PCT_FULL / 2;
  localparam int TRQ_FULL   = 16'h5555;
  localparam int PCT_MAX    = 32767;
  localparam int PCT_MIN    = -32768;

  // Torque rounding: t = c*TRQ_FULL + PCT_HALF, then t / PCT_FULL by reciprocal
  localparam int    TRQ_PROD_W = 22;
  localparam int    RECIP_SH   = TRQ_PROD_W + 7;
  localparam int    RECIP_W    = RECIP_SH - 6;
  localparam longint RECIP     = ((longint'(1) << RECIP_SH) + PCT_FULL - 1) / PCT_FULL;
  localparam int    PM_W       = TRQ_PROD_W + RECIP_W;   // reciprocal product

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ADC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_MIN = 1'b0,
    CFG_RAW_MAX = 1'b1
  } cfg_idx_t;

  // Front-to-back queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic [MAG_W-1:0]    num_mag;    // |numerator|
    logic [ADC_BITS-1:0] den;        // |span|
    logic                q_neg;      // truncated quotient is negative
    logic                differ;     // numerator nonzero with sign unlike span
    logic                zero_span;  // raw_min equals raw_max
  } pats_item_t;

  // One stage of the restoring divider
  typedef struct packed {
    logic [ADC_BITS-1:0] rem;        // partial remainder
    logic [MAG_W-1:0]    nq;         // dividend bits left, quotient bits in
    logic [ADC_BITS-1:0] den;
    logic                q_neg;
    logic                differ;
    logic                zero_span;
  } div_st_t;

endpackage

`default_nettype wire

// ===== rtl/pats_if.sv =====
// ----------------------------------------------------------------------------
// pats_in_if / pats_out_if: valid-ready channels of the scaler
// Sample channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface pats_in_if;
  import pats_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface pats_out_if;
  import pats_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PCT_W-1:0] pedal_percent;
  logic [TRQ_W-1:0]        torque_code;

  modport source (output valid, output pedal_percent, output torque_code, input ready);
  modport sink   (input valid, input pedal_percent, input torque_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/pats_front.sv =====
// ----------------------------------------------------------------------------
// pats_front: configuration registers and sample classification
// Forms the rounding numerator and the span, splits them into magnitudes
// and sign flags and pushes the transaction into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pats_front
  import pats_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  pats_in_if.sink                    in_ch,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output pats_item_t                 push_item
);

  logic [ADC_BITS-1:0] raw_min_r, raw_max_r;

  logic signed [SPAN_W-1:0] diff, span, span_adj, half;
  logic signed [NUM_W-1:0]  num, num_abs, span_abs;
  logic                     num_neg, num_nz, span_neg, zero_span;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_min_r <= '0;
      raw_max_r <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RAW_MIN: raw_min_r <= cfg_wdata[ADC_BITS-1:0];
        CFG_RAW_MAX: raw_max_r <= cfg_wdata[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Numerator (x - min)*100 + span/2, half span truncated toward zero
  always_comb begin
    diff      = $signed({1'b0, in_ch.raw_sample}) - $signed({1'b0, raw_min_r});
    span      = $signed({1'b0, raw_max_r}) - $signed({1'b0, raw_min_r});
    span_neg  = span[SPAN_W-1];
    zero_span = (span == '0);
    span_adj  = span + $signed({{(SPAN_W-1){1'b0}}, span_neg});
    half      = span_adj >>> 1;
    num       = NUM_W'(diff) * $signed(NUM_W'(PCT_FULL)) + NUM_W'(half);
    num_neg   = num[NUM_W-1];
    num_nz    = (num != '0);
    num_abs   = num_neg ? -num : num;
    span_abs  = span_neg ? -NUM_W'(span) : NUM_W'(span);
  end

  // Classified transaction
  always_comb begin
    push_item.num_mag   = num_abs[MAG_W-1:0];
    push_item.den       = span_abs[ADC_BITS-1:0];
    push_item.q_neg     = num_neg ^ span_neg;
    push_item.differ    = (num_neg && !span_neg && !zero_span) ||
                          (!num_neg && num_nz && span_neg);
    push_item.zero_span = zero_span;
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

`default_nettype wire

// ===== rtl/pats_fifo.sv =====
// ----------------------------------------------------------------------------
// pats_fifo: short queue between front and back
// Register-based FIFO; lets the front keep accepting while the back stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pats_fifo
  import pats_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  pats_item_t       push_item,
  output logic             pop_valid,
  input  wire logic        pop_ready,
  output pats_item_t       pop_item
);

  pats_item_t           mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (FIFO_AW+1)'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pats_back.sv =====
// ----------------------------------------------------------------------------
// pats_back: divider pipeline, saturation and torque mapping
// One quotient bit per stage, then sign fix-up, saturation and clamping,
// then the torque rounding by reciprocal, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pats_back
  import pats_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   pop_valid,
  output logic        pop_ready,
  input  pats_item_t  pop_item,
  pats_out_if.source  out_ch
);

  logic                    adv;
  logic [MAG_W:0]          div_vld_r;
  div_st_t                 div_r   [MAG_W+1];
  div_st_t                 div_nxt [MAG_W+1];

  logic                    p1_vld_r, p2_vld_r, out_valid_r;
  logic signed [Q_W-1:0]   q_r, q_nxt;
  logic signed [PCT_W-1:0] pct_r, pct_nxt, out_pct_r;
  logic [TRQ_PROD_W-1:0]   t_r, t_nxt;
  logic [CLAMP_W-1:0]      clamp;
  logic [PM_W-1:0]         prod;
  logic [TRQ_W-1:0]        out_trq_r;

  // The whole back end moves when the output register is free or drained
  assign adv       = !out_valid_r || out_ch.ready;
  assign pop_ready = adv;

  // Divider entry
  always_comb begin
    div_nxt[0].rem       = '0;
    div_nxt[0].nq        = pop_item.num_mag;
    div_nxt[0].den       = pop_item.den;
    div_nxt[0].q_neg     = pop_item.q_neg;
    div_nxt[0].differ    = pop_item.differ;
    div_nxt[0].zero_span = pop_item.zero_span;
  end

  // Restoring divider steps, one quotient bit each
  for (genvar k = 0; k < MAG_W; k++) begin : g_div
    logic [ADC_BITS:0] trial;
    logic              ge;
    always_comb begin
      trial = {div_r[k].rem, div_r[k].nq[MAG_W-1]};
      ge    = (trial >= {1'b0, div_r[k].den});
      div_nxt[k+1]     = div_r[k];
      div_nxt[k+1].rem = ge ? ADC_BITS'(trial - {1'b0, div_r[k].den})
                            : trial[ADC_BITS-1:0];
      div_nxt[k+1].nq  = {div_r[k].nq[MAG_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r <= '0;
    end else if (adv) begin
      div_vld_r <= {div_vld_r[MAG_W-1:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= MAG_W; i++) begin
        div_r[i] <= div_nxt[i];
      end
    end
  end

  // Truncated signed quotient, minus one when signs differ; zero span is 50
  always_comb begin
    q_nxt = $signed({2'b00, div_r[MAG_W].nq});
    if (div_r[MAG_W].q_neg)  q_nxt = -q_nxt;
    if (div_r[MAG_W].differ) q_nxt = q_nxt - Q_W'(1);
    if (div_r[MAG_W].zero_span) q_nxt = Q_W'(PCT_HALF);
  end

  // Saturate to 16 bits, clamp to 0..100, start torque rounding
  always_comb begin
    if (q_r > $signed(Q_W'(PCT_MAX))) begin
      pct_nxt = PCT_W'(PCT_MAX);
    end else if (q_r < $signed(Q_W'(PCT_MIN))) begin
      pct_nxt = PCT_W'(PCT_MIN);
    end else begin
      pct_nxt = q_r[PCT_W-1:0];
    end
    if (q_r[Q_W-1]) begin
      clamp = '0;
    end else if (q_r > $signed(Q_W'(PCT_FULL))) begin
      clamp = CLAMP_W'(PCT_FULL);
    end else begin
      clamp = q_r[CLAMP_W-1:0];
    end
    t_nxt = TRQ_PROD_W'(clamp) * TRQ_PROD_W'(TRQ_FULL) + TRQ_PROD_W'(PCT_HALF);
  end

  // Division by 100 as multiply by the scaled reciprocal
  assign prod = PM_W'(t_r) * PM_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r    <= div_vld_r[MAG_W];
      p2_vld_r    <= p1_vld_r;
      out_valid_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r       <= q_nxt;
      pct_r     <= pct_nxt;
      t_r       <= t_nxt;
      out_pct_r <= pct_r;
      out_trq_r <= prod[RECIP_SH +: TRQ_W];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pedal_percent = out_pct_r;
  assign out_ch.torque_code   = out_trq_r;

endmodule

`default_nettype wire

// ===== rtl/pedal_adc_to_torque_scaler.sv =====
// ----------------------------------------------------------------------------
// pedal_adc_to_torque_scaler: pedal ADC sample to percent and torque code
// Top level: front classifier, queue and divider back end.
// ----------------------------------------------------------------------------
// Usage
//   in_ch  : valid/ready channel carrying one raw_sample per transaction.
//   out_ch : valid/ready channel with pedal_percent (signed, saturated to
//            16 bits, rounded to nearest) and torque_code (0..0x5555).
//   cfg_*  : write port; cfg_idx 0 is raw_min, 1 is raw_max. Write only
//            while no transaction is in flight.
// Timing
//   One transaction per cycle sustained while out_ch.ready stays high. An
//   accepted sample passes the queue, the divider pipeline (one quotient bit
//   per stage), then the quotient, saturation and output registers.
// Reset
//   rst_n is synchronous; raw_min returns to 0, raw_max to all ones and
//   the queue and pipeline empty.
// Backpressure
//   While a result waits with out_ch.ready low the back end holds; the
//   four-entry queue keeps in_ch.ready high until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module pedal_adc_to_torque_scaler
  import pats_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  pats_in_if.sink                    in_ch,
  pats_out_if.source                 out_ch
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  pats_item_t push_item, pop_item;

  pats_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pats_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  pats_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/pats_checker.sv =====
// ----------------------------------------------------------------------------
// pats_checker: port-level assertions for the scaler
// Checks output hold under stall, reset behavior and percent/torque
// consistency; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pats_checker
  import pats_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [PCT_W-1:0] out_pedal_percent,
  input wire logic [TRQ_W-1:0]        out_torque_code
);

  // Stalled result transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pedal_percent) &&
                                $stable(out_torque_code))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Released or below-span pedal gives zero torque
  a_trq_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pedal_percent <= 0 |-> out_torque_code == '0)
    else $error("nonzero torque at or below zero percent");

  // Full pedal or beyond gives full torque
  a_trq_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pedal_percent >= $signed(PCT_W'(PCT_FULL)) |->
      out_torque_code == TRQ_W'(TRQ_FULL))
    else $error("torque not full at or above full percent");

  // Half pedal maps to the rounded half code
  a_trq_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pedal_percent == $signed(PCT_W'(PCT_HALF)) |->
      out_torque_code == TRQ_W'((TRQ_FULL + 1) / 2))
    else $error("torque wrong at half percent");

endmodule

bind pedal_adc_to_torque_scaler pats_checker u_pats_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_pedal_percent (out_ch.pedal_percent),
  .out_torque_code   (out_ch.torque_code)
);

`default_nettype wire

// ===== bench/pedal_adc_to_torque_scaler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_adc_to_torque_scaler_test: self-checking bench for the pedal scaler
// Feeds ADC samples over several raw_min / raw_max settings (reset values,
// extremes, reversed and zero spans, random spans), predicts the rounded
// percent and torque code of every accepted sample, and checks each result
// transaction in order. Both channels idle at random, the receiver holds
// off once long enough to fill the block, and the sender pauses to drain.
// ----------------------------------------------------------------------------

module pedal_adc_to_torque_scaler_test;
  import pats_pkg::*;

  localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
  localparam int SETTLE_CYCLES = ADC_BITS + 16;   // pipeline latency plus margin
  localparam int HOLD_CYCLES   = 120;             // receiver hold-off, beyond block capacity
  localparam int STALL_LIMIT   = 2000;            // cycles with no transaction at all
  localparam int IDLE_PCT      = 27;

  typedef struct {
    logic signed [PCT_W-1:0] percent;
    logic [TRQ_W-1:0]        torque;
  } pedal_reading_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pats_in_if  in_ch();
  pats_out_if out_ch();

  pedal_adc_to_torque_scaler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Bench copy of the span registers
  int span_lo = 0;
  int span_hi = ADC_MAX;

  logic [ADC_BITS-1:0] pending_samples[$];
  pedal_reading_t      expected_readings[$];
  int mismatches    = 0;
  int readings_out  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  bit steady_run    = 1'b0;
  int stall_cycles  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rounded linear rescale onto percent, saturated, then clamped torque code
  function automatic pedal_reading_t scale_sample(input logic [ADC_BITS-1:0] sample,
                                                  input int lo, input int hi);
    pedal_reading_t r;
    longint span;
    longint num;
    longint quo;
    longint clamped;
    span = longint'(hi) - longint'(lo);
    if (span == 0) begin
      quo = PCT_HALF;
    end else begin
      num = (longint'(sample) - longint'(lo)) * PCT_FULL + span / 2;
      quo = num / span;
      // truncation went the wrong way when signs differ
      if ((num < 0 && span > 0) || (num > 0 && span < 0)) begin
        quo = quo - 1;
      end
    end
    if (quo > PCT_MAX) quo = PCT_MAX;
    if (quo < PCT_MIN) quo = PCT_MIN;
    clamped = quo;
    if (clamped > PCT_FULL) clamped = PCT_FULL;
    if (clamped < 0) clamped = 0;
    r.percent = quo[PCT_W-1:0];
    r.torque  = TRQ_W'((clamped * TRQ_FULL + PCT_HALF) / PCT_FULL);
    return r;
  endfunction

  // Random sample: anywhere, inside the span, or just around its ends
  function automatic logic [ADC_BITS-1:0] pick_sample(input int lo, input int hi);
    int a;
    int b;
    int pick;
    int v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    pick = $urandom_range(9);
    if (pick < 5) begin
      v = $urandom_range(ADC_MAX);
    end else if (pick < 8) begin
      v = $urandom_range(b, a);
    end else begin
      v = ($urandom_range(1) ? lo : hi) + $urandom_range(6) - 3;
      if (v < 0) v = 0;
      if (v > ADC_MAX) v = ADC_MAX;
    end
    return v[ADC_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    if (idx == CFG_RAW_MIN) span_lo = value;
    else span_hi = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sender stops until the block has returned everything, then lets it settle;
  // checked mid-cycle so the driver and monitor updates of the edge are in
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_ch.valid || expected_readings.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_span(input int lo, input int hi);
    wait_drained();
    write_reg(CFG_RAW_MIN, lo);
    write_reg(CFG_RAW_MAX, hi);
  endtask

  task automatic queue_samples(input int vals[$]);
    foreach (vals[i]) pending_samples.push_back(vals[i][ADC_BITS-1:0]);
  endtask

  // Sample driver: new transaction when the previous one was taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_samples.size() != 0 &&
          (steady_run || hold_left != 0 || $urandom_range(99) >= IDLE_PCT)) begin
        in_ch.valid      <= 1'b1;
        in_ch.raw_sample <= pending_samples.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && readings_out >= 40) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on sample transactions, check result transactions
  always @(posedge clk) begin
    pedal_reading_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_readings.push_back(scale_sample(in_ch.raw_sample, span_lo, span_hi));
      end
      if (out_ch.valid && out_ch.ready) begin
        readings_out <= readings_out + 1;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected result percent=%0d torque=%0d",
                                    out_ch.pedal_percent, out_ch.torque_code));
        end else begin
          want = expected_readings.pop_front();
          if (out_ch.pedal_percent !== want.percent) begin
            report_mismatch($sformatf("pedal_percent got %0d expected %0d",
                                      out_ch.pedal_percent, want.percent));
          end
          if (out_ch.torque_code !== want.torque) begin
            report_mismatch($sformatf("torque_code got %0d expected %0d",
                                      out_ch.torque_code, want.torque));
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    int lo;
    int hi;
    int count;
    int mode;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_RAW_MIN;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.raw_sample = '0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset span: extremes, midpoint, alternating bit patterns
    queue_samples('{0, ADC_MAX, 2048, 1, ADC_MAX - 1, 'hAAA, 'h555, 41});
    // Narrower span, samples at both ends and outside it
    set_span(100, 3900);
    queue_samples('{100, 3900, 0, ADC_MAX, 2000});
    // Reversed span
    set_span(3900, 100);
    queue_samples('{100, 3900, 2000});
    // Zero span gives a fixed half percent
    set_span(2000, 2000);
    queue_samples('{2000, 0, ADC_MAX});
    // Unit span, far sample saturates high
    set_span(0, 1);
    queue_samples('{0, 1, ADC_MAX});
    // Unit span at the top, far sample saturates low
    set_span(ADC_MAX - 1, ADC_MAX);
    queue_samples('{0, ADC_MAX});

    // Random phases; the first is long enough for the receiver hold-off
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        lo = ADC_MAX;
        hi = 0;
      end else begin
        mode = $urandom_range(9);
        lo = $urandom_range(ADC_MAX);
        if (mode == 0) begin
          hi = lo;
        end else if (mode < 3) begin
          hi = $urandom_range(ADC_MAX);
          if (hi > lo) begin
            hi = lo + hi;
            lo = hi - lo;
            hi = hi - lo;
          end
        end else if (mode == 3) begin
          hi = lo + $urandom_range(40, 1);
          if (hi > ADC_MAX) hi = ADC_MAX;
        end else begin
          lo = $urandom_range(800);
          hi = $urandom_range(ADC_MAX, 3300);
        end
      end
      set_span(lo, hi);
      count = (ph == 0) ? 260 : 70;
      steady_run = (ph == 2);
      for (int i = 0; i < count; i++) begin
        // mid-phase pause: let every result come back before going on
        if (ph == 3 && i == count / 2) wait_drained();
        pending_samples.push_back(pick_sample(span_lo, span_hi));
      end
      wait_drained();
      steady_run = 1'b0;
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pats_pkg.sv
rtl/pats_if.sv
rtl/pats_front.sv
rtl/pats_fifo.sv
rtl/pats_back.sv
rtl/pedal_adc_to_torque_scaler.sv
rtl/pats_checker.sv
bench/pedal_adc_to_torque_scaler_test.sv
